@@ hdl/ntpoc_pkg.sv @@
// Shared types, constants and timestamp conversion functions for the NTP
// clock offset correction pipeline. Depends on nothing else.
package ntpoc_pkg;

	localparam logic [31:0] EPOCH_GAP    = 32'h83aa7e80;
	localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
	localparam logic [19:0] HALF_SEC     = 20'd500000;
	localparam logic [12:0] FRAC_SCALE   = 13'd4294;
	localparam logic [10:0] FRAC_TRIM    = 11'd1981;
	localparam logic [9:0]  US_TRIM      = 10'd759;
	localparam logic [15:0] US_ROUND     = 16'd32768;

	typedef struct packed {
		logic [31:0] origin_seconds;
		logic [31:0] origin_fraction;
		logic [31:0] receive_seconds;
		logic [31:0] receive_fraction;
		logic [31:0] transmit_seconds;
		logic [31:0] transmit_fraction;
		logic [31:0] local_seconds;
		logic [19:0] local_micros;
	} in_word_t;

	// Offset sum split into a seconds part and a small microsecond part.
	typedef struct packed {
		logic signed [34:0] sec_sum;
		logic signed [22:0] us_sum;
		logic [19:0]        local_rt;
		logic [31:0]        local_seconds;
	} sum_t;

	// Halved offset in floor form: off_q * 1e6 + off_r, off_r in 0..999999.
	typedef struct packed {
		logic signed [33:0] off_q;
		logic [19:0]        off_r;
		logic [19:0]        local_rt;
		logic [31:0]        local_seconds;
	} half_t;

	// Binary fraction to microseconds: (f >> 12) - 759 * (((f >> 10) + 32768) >> 16).
	// The result is never negative and always fits in 20 bits.
	function automatic logic [19:0] frac_to_us(input logic [31:0] f);
		logic [22:0] rnd;
		logic [15:0] corr;
		rnd  = {1'b0, f[31:10]} + 23'(US_ROUND);
		corr = 16'(US_TRIM) * 16'(rnd[22:16]);
		return f[31:12] - 20'(corr);
	endfunction

	// Microseconds to binary fraction: 4294*us + ((1981*us) >> 11), modulo 2^32.
	function automatic logic [31:0] us_to_frac(input logic [19:0] us);
		logic [32:0] a;
		logic [30:0] b;
		a = 33'(FRAC_SCALE) * 33'(us);
		b = 31'(FRAC_TRIM) * 31'(us);
		return 32'(a + 33'(b[30:11]));
	endfunction

endpackage

@@ hdl/ntpoc_front.sv @@
// Front of the pipeline: rebases seconds, converts fractions to microseconds
// and forms the offset sums. Depends on ntpoc_pkg.
module ntpoc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_stall,
	input  ntpoc_pkg::in_word_t up_data,
	output logic             dn_valid,
	input  logic             dn_stall,
	output ntpoc_pkg::sum_t  dn_data
);
	import ntpoc_pkg::*;

	logic        v_s1, v_s2;
	logic        st1, st2;
	logic [31:0] s1_s1, s2_s1, s3_s1, lsec_s1, lfrac_s1;
	logic [19:0] u1_s1, u2_s1, u3_s1, lus_s1;
	sum_t        sum_s2;

	assign st2      = v_s2 && dn_stall;
	assign st1      = v_s1 && st2;
	assign up_stall = st1;
	assign dn_valid = v_s2;
	assign dn_data  = sum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (!st1) v_s1 <= up_valid;
			if (!st2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!st1) begin
			s1_s1    <= up_data.origin_seconds - EPOCH_GAP;
			s2_s1    <= up_data.receive_seconds - EPOCH_GAP;
			s3_s1    <= up_data.transmit_seconds - EPOCH_GAP;
			u1_s1    <= frac_to_us(up_data.origin_fraction);
			u2_s1    <= frac_to_us(up_data.receive_fraction);
			u3_s1    <= frac_to_us(up_data.transmit_fraction);
			lsec_s1  <= up_data.local_seconds;
			lus_s1   <= up_data.local_micros;
			lfrac_s1 <= us_to_frac(up_data.local_micros);
		end
		if (!st2) begin
			sum_s2.sec_sum <= $signed({3'b000, s2_s1}) + $signed({3'b000, s3_s1})
				- $signed({3'b000, s1_s1}) - $signed({3'b000, lsec_s1});
			sum_s2.us_sum <= $signed({3'b000, u2_s1}) + $signed({3'b000, u3_s1})
				- $signed({3'b000, u1_s1}) - $signed({3'b000, lus_s1});
			sum_s2.local_rt      <= frac_to_us(lfrac_s1);
			sum_s2.local_seconds <= lsec_s1;
		end
	end

endmodule

@@ hdl/ntpoc_offset.sv @@
// Middle of the pipeline: brings the offset sum into floor form and halves it
// with truncation toward zero. Depends on ntpoc_pkg.
module ntpoc_offset (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_stall,
	input  ntpoc_pkg::sum_t  up_data,
	output logic             dn_valid,
	input  logic             dn_stall,
	output ntpoc_pkg::half_t dn_data
);
	import ntpoc_pkg::*;

	localparam logic signed [22:0] SEC1 = 23'sd1000000;
	localparam logic signed [22:0] SEC2 = 23'sd2000000;
	localparam logic signed [22:0] SEC3 = 23'sd3000000;

	logic               v_s3, v_s4;
	logic               st3, st4;
	logic signed [2:0]  k;
	logic signed [22:0] r_full;
	logic signed [34:0] q_s3;
	logic [19:0]        r_s3;
	logic [19:0]        rt_s3;
	logic [31:0]        lsec_s3;
	logic signed [33:0] qh;
	logic [20:0]        r2a;
	half_t              half_d;
	half_t              half_s4;

	assign st4      = v_s4 && dn_stall;
	assign st3      = v_s3 && st4;
	assign up_stall = st3;
	assign dn_valid = v_s4;
	assign dn_data  = half_s4;

	// Whole seconds folded out of the microsecond sum, leaving 0..999999.
	always_comb begin
		if (up_data.us_sum >= SEC1) begin
			k      = 3'sd1;
			r_full = up_data.us_sum - SEC1;
		end else if (up_data.us_sum >= 23'sd0) begin
			k      = 3'sd0;
			r_full = up_data.us_sum;
		end else if (up_data.us_sum >= -SEC1) begin
			k      = -3'sd1;
			r_full = up_data.us_sum + SEC1;
		end else if (up_data.us_sum >= -SEC2) begin
			k      = -3'sd2;
			r_full = up_data.us_sum + SEC2;
		end else begin
			k      = -3'sd3;
			r_full = up_data.us_sum + SEC3;
		end
	end

	// Halving: an odd second count moves half a second into the remainder, and
	// a negative odd sum gets one added to turn the floor into truncation.
	always_comb begin
		qh  = q_s3[34:1];
		r2a = 21'(r_s3[19:1]) + (q_s3[0] ? 21'(HALF_SEC) : 21'd0)
			+ 21'(q_s3[34] & r_s3[0]);
		half_d.local_rt      = rt_s3;
		half_d.local_seconds = lsec_s3;
		if (r2a == 21'(USEC_PER_SEC)) begin
			half_d.off_q = qh + 34'sd1;
			half_d.off_r = 20'd0;
		end else begin
			half_d.off_q = qh;
			half_d.off_r = r2a[19:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (!st3) v_s3 <= up_valid;
			if (!st4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (!st3) begin
			q_s3    <= up_data.sec_sum + {{32{k[2]}}, k};
			r_s3    <= r_full[19:0];
			rt_s3   <= up_data.local_rt;
			lsec_s3 <= up_data.local_seconds;
		end
		if (!st4) begin
			half_s4 <= half_d;
		end
	end

	a_rem_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> r_s3 < USEC_PER_SEC)
		else $error("stage 3 remainder out of range");
	a_rem_s4: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> half_s4.off_r < USEC_PER_SEC)
		else $error("stage 4 remainder out of range");
	a_hold_s4: assert property (@(posedge clk) disable iff (!arst_n)
		st4 |=> v_s4 && $stable(half_s4))
		else $error("stage 4 lost its word under stall");

endmodule

@@ hdl/ntpoc_apply.sv @@
// Back of the pipeline: applies the halved offset to the local time and
// normalizes the microseconds. Depends on ntpoc_pkg.
module ntpoc_apply (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             up_valid,
	output logic             up_stall,
	input  ntpoc_pkg::half_t up_data,
	output logic             dn_valid,
	input  logic             dn_stall,
	output logic [31:0]      dn_seconds,
	output logic [19:0]      dn_micros
);
	import ntpoc_pkg::*;

	localparam logic signed [21:0] SEC1 = 22'sd1000000;

	logic               v_s5, v_s6;
	logic               st5, st6;
	logic signed [33:0] off_sec;
	logic signed [21:0] off_us;
	logic [31:0]        sec_s5;
	logic signed [21:0] us_s5;
	logic [31:0]        sec_s6;
	logic [19:0]        us_s6;

	assign st6        = v_s6 && dn_stall;
	assign st5        = v_s5 && st6;
	assign up_stall   = st5;
	assign dn_valid   = v_s6;
	assign dn_seconds = sec_s6;
	assign dn_micros  = us_s6;

	// Floor form to C division: a negative offset with a remainder rounds the
	// seconds up and gives the remainder the sign of the offset.
	always_comb begin
		if (up_data.off_q[33] && up_data.off_r != 20'd0) begin
			off_sec = up_data.off_q + 34'sd1;
			off_us  = $signed({2'b00, up_data.off_r}) - SEC1;
		end else begin
			off_sec = up_data.off_q;
			off_us  = $signed({2'b00, up_data.off_r});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (!st5) v_s5 <= up_valid;
			if (!st6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (!st5) begin
			sec_s5 <= up_data.local_seconds + off_sec[31:0];
			us_s5  <= $signed({2'b00, up_data.local_rt}) + off_us;
		end
		if (!st6) begin
			if (us_s5 < 22'sd0) begin
				sec_s6 <= sec_s5 - 32'd1;
				us_s6  <= 20'(us_s5 + SEC1);
			end else if (us_s5 >= SEC1) begin
				sec_s6 <= sec_s5 + 32'd1;
				us_s6  <= 20'(us_s5 - SEC1);
			end else begin
				sec_s6 <= sec_s5;
				us_s6  <= us_s5[19:0];
			end
		end
	end

endmodule

@@ hdl/ntp_clock_offset_correction_top.sv @@
// Top level of the NTP clock offset correction pipeline.
// Depends on ntpoc_pkg, ntpoc_front, ntpoc_offset and ntpoc_apply.
//
// Usage: the input channel takes one word per reply: the origin, server
// receive and server transmit NTP timestamps (seconds since 1900 and a
// binary fraction) together with the local arrival time in Unix seconds and
// microseconds. A word is taken at a rising edge with in_valid high and
// in_stall low. The output channel returns one word per input word, the local
// time corrected by half the round-trip offset, taken at an edge with
// out_valid high and out_stall low.
// A word accepted at the input passes through the six register stages in order and leaves
// from the last. Throughput is one word per cycle while the receiver does not stall; each
// stage holds one word, so a new word enters while earlier ones are in flight.
// The two timestamp-conversion stages, the offset normalization and halving
// stages, and the apply and normalize stages make up those six.
// Reset clears every stage valid bit at once, so the block is empty and
// ready right after reset; there is no state beyond the words in flight.
// When the receiver stalls, the output word holds and stall backs up stage
// by stage: empty stages still fill, and in_stall rises only when all six
// stages are full, so no word is lost or repeated.
module ntp_clock_offset_correction_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] origin_seconds,
	input  logic [31:0] origin_fraction,
	input  logic [31:0] receive_seconds,
	input  logic [31:0] receive_fraction,
	input  logic [31:0] transmit_seconds,
	input  logic [31:0] transmit_fraction,
	input  logic [31:0] local_seconds,
	input  logic [19:0] local_micros,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] corrected_seconds,
	output logic [19:0] corrected_micros
);
	import ntpoc_pkg::*;

	in_word_t in_word;
	sum_t     sum_word;
	half_t    half_word;
	logic     sum_valid, sum_stall;
	logic     half_valid, half_stall;

	assign in_word.origin_seconds    = origin_seconds;
	assign in_word.origin_fraction   = origin_fraction;
	assign in_word.receive_seconds   = receive_seconds;
	assign in_word.receive_fraction  = receive_fraction;
	assign in_word.transmit_seconds  = transmit_seconds;
	assign in_word.transmit_fraction = transmit_fraction;
	assign in_word.local_seconds     = local_seconds;
	assign in_word.local_micros      = local_micros;

	// Stages 1 and 2: timestamp conversion and offset sums.
	ntpoc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (in_valid),
		.up_stall (in_stall),
		.up_data  (in_word),
		.dn_valid (sum_valid),
		.dn_stall (sum_stall),
		.dn_data  (sum_word)
	);

	// Stages 3 and 4: floor form and halving toward zero.
	ntpoc_offset u_offset (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sum_valid),
		.up_stall (sum_stall),
		.up_data  (sum_word),
		.dn_valid (half_valid),
		.dn_stall (half_stall),
		.dn_data  (half_word)
	);

	// Stages 5 and 6: correction of the local time and the output register.
	ntpoc_apply u_apply (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (half_valid),
		.up_stall   (half_stall),
		.up_data    (half_word),
		.dn_valid   (out_valid),
		.dn_stall   (out_stall),
		.dn_seconds (corrected_seconds),
		.dn_micros  (corrected_micros)
	);

	// The input can only back up when the whole pipeline is full and the
	// receiver is stalling.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall && sum_valid && half_valid)
		else $error("input stalled while the pipeline has room");
	a_micros_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> corrected_micros < USEC_PER_SEC)
		else $error("corrected microseconds not normalized");
	a_inner_stall: assert property (@(posedge clk) disable iff (!arst_n)
		half_stall |-> out_stall)
		else $error("inner stall without output stall");

endmodule

@@ dv/tb_ntp_clock_offset_correction_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for ntp_clock_offset_correction_top: directed and random NTP replies,
// with the expected corrected time computed in the bench. Depends on ntpoc_pkg and the RTL.
module tb_ntp_clock_offset_correction_top;

	// The NTP era starts in 1900 and Unix time in 1970. This is the gap in seconds.
	localparam logic [31:0] NTP_UNIX_GAP   = 32'h83aa7e80;
	localparam longint      MICROS_PER_SEC = 1000000;
	// A plausible present-day NTP second and its Unix counterpart, used by directed words.
	localparam logic [31:0] SAMPLE_NTP     = 32'he000_0000;
	localparam logic [31:0] SAMPLE_UNIX    = SAMPLE_NTP - NTP_UNIX_GAP;
	// The pipeline is six stages deep; the quiet cycles at the end leave room for strays.
	localparam int          DRAIN_CYCLES   = 12;
	// The slowest correct run is about 1700 words.
	localparam int          CYCLE_LIMIT    = 200000;
	localparam int          MAX_PRINTED    = 100;

	typedef struct packed {
		logic [31:0] seconds;
		logic [19:0] micros;
	} corrected_time_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] origin_seconds = '0;
	logic [31:0] origin_fraction = '0;
	logic [31:0] receive_seconds = '0;
	logic [31:0] receive_fraction = '0;
	logic [31:0] transmit_seconds = '0;
	logic [31:0] transmit_fraction = '0;
	logic [31:0] local_seconds = '0;
	logic [19:0] local_micros = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] corrected_seconds;
	logic [19:0] corrected_micros;

	// Expected corrected times, oldest first. The sender adds one per accepted word and the
	// checker takes one per accepted result.
	corrected_time_t pending_times[$];
	corrected_time_t oldest_time;
	int              mismatch_count = 0;
	int              cycle_count = 0;
	// When set, the matching side idles for a random stretch before each word.
	bit              send_idle = 1'b1;
	bit              recv_idle = 1'b1;

	ntp_clock_offset_correction_top uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.origin_seconds   (origin_seconds),
		.origin_fraction  (origin_fraction),
		.receive_seconds  (receive_seconds),
		.receive_fraction (receive_fraction),
		.transmit_seconds (transmit_seconds),
		.transmit_fraction(transmit_fraction),
		.local_seconds    (local_seconds),
		.local_micros     (local_micros),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.corrected_seconds(corrected_seconds),
		.corrected_micros (corrected_micros)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// A binary fraction of a second becomes microseconds by a shift and a small correction
	// that accounts for 2^32 / 10^6 not being exactly 4096.
	function automatic logic [31:0] fraction_to_micros(input logic [31:0] f);
		logic [31:0] rounded;
		rounded = ((f >> 10) + 32'd32768) >> 16;
		return (f >> 12) - 32'd759 * rounded;
	endfunction

	// Microseconds back to a binary fraction, wrapping at 32 bits for out-of-range inputs.
	function automatic logic [31:0] micros_to_fraction(input logic [19:0] us);
		logic [63:0] wide;
		wide = 64'd4294 * 64'(us) + ((64'd1981 * 64'(us)) >> 11);
		return wide[31:0];
	endfunction

	// An NTP timestamp as signed microseconds since 1970. Seconds before 1970 wrap around
	// and so land far in the future.
	function automatic longint ntp_to_micros(input logic [31:0] sec, input logic [31:0] frac);
		logic [31:0] unix_sec;
		longint      whole;
		longint      part;
		unix_sec = sec - NTP_UNIX_GAP;
		whole = {32'd0, unix_sec};
		part = {32'd0, fraction_to_micros(frac)};
		return whole * MICROS_PER_SEC + part;
	endfunction

	// Corrected local time for one reply: half of the summed clock differences, truncated
	// toward zero, is added to the local time, and the microseconds take one carry or borrow.
	function automatic corrected_time_t predict_corrected_time(input ntpoc_pkg::in_word_t w);
		longint          t1, t2, t3, t4;
		longint          offset, off_sec, off_us, us;
		logic [31:0]     sec;
		corrected_time_t r;
		t1 = ntp_to_micros(w.origin_seconds, w.origin_fraction);
		t2 = ntp_to_micros(w.receive_seconds, w.receive_fraction);
		t3 = ntp_to_micros(w.transmit_seconds, w.transmit_fraction);
		t4 = longint'({32'd0, w.local_seconds}) * MICROS_PER_SEC
			+ longint'({44'd0, w.local_micros});
		offset = ((t2 - t1) + (t3 - t4)) / 2;
		off_sec = offset / MICROS_PER_SEC;
		off_us = offset % MICROS_PER_SEC;
		sec = w.local_seconds + off_sec[31:0];
		us = longint'({32'd0, fraction_to_micros(micros_to_fraction(w.local_micros))}) + off_us;
		if (us < 0) begin
			sec = sec - 32'd1;
			us = us + MICROS_PER_SEC;
		end else if (us >= MICROS_PER_SEC) begin
			sec = sec + 32'd1;
			us = us - MICROS_PER_SEC;
		end
		r.seconds = sec;
		r.micros = us[19:0];
		return r;
	endfunction

	function automatic ntpoc_pkg::in_word_t pack_reply(
		input logic [31:0] os, input logic [31:0] ofr,
		input logic [31:0] rs, input logic [31:0] rfr,
		input logic [31:0] ts, input logic [31:0] tfr,
		input logic [31:0] ls, input logic [19:0] lus
	);
		ntpoc_pkg::in_word_t w;
		w.origin_seconds = os;
		w.origin_fraction = ofr;
		w.receive_seconds = rs;
		w.receive_fraction = rfr;
		w.transmit_seconds = ts;
		w.transmit_fraction = tfr;
		w.local_seconds = ls;
		w.local_micros = lus;
		return w;
	endfunction

	// A reply as a real exchange would produce it: the origin sits at or just before the local
	// arrival, the server clock is skewed by anything from a few seconds to the whole 32-bit
	// range, and the server turns the request around within a second. One word in sixteen
	// carries local microseconds above the legal range.
	function automatic ntpoc_pkg::in_word_t random_reply();
		ntpoc_pkg::in_word_t w;
		logic [31:0]         skew;
		w.local_seconds = $urandom();
		if ($urandom_range(0, 15) == 0)
			w.local_micros = 20'($urandom_range(1000000, 20'hfffff));
		else
			w.local_micros = 20'($urandom_range(0, 999999));
		case ($urandom_range(0, 3))
			0: skew = 32'($urandom_range(0, 6)) - 32'd3;
			1: skew = 32'($urandom_range(0, 2000)) - 32'd1000;
			2: skew = $urandom();
			default: skew = 32'd0;
		endcase
		w.origin_seconds = w.local_seconds + NTP_UNIX_GAP - 32'($urandom_range(0, 1));
		w.receive_seconds = w.origin_seconds + skew + 32'($urandom_range(0, 1));
		w.transmit_seconds = w.receive_seconds + 32'($urandom_range(0, 1));
		w.origin_fraction = $urandom();
		w.receive_fraction = $urandom();
		w.transmit_fraction = $urandom();
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Sends one word and, once it is accepted, records the corrected time it must produce.
	// The payload holds steady while the block stalls.
	task automatic send_reply(input ntpoc_pkg::in_word_t w);
		int gap;
		gap = send_idle ? $urandom_range(0, 5) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		origin_seconds <= w.origin_seconds;
		origin_fraction <= w.origin_fraction;
		receive_seconds <= w.receive_seconds;
		receive_fraction <= w.receive_fraction;
		transmit_seconds <= w.transmit_seconds;
		transmit_fraction <= w.transmit_fraction;
		local_seconds <= w.local_seconds;
		local_micros <= w.local_micros;
		do @(posedge clk); while (in_stall);
		pending_times.push_back(predict_corrected_time(w));
	endtask

	// Drops valid and waits until every expected result has come back. The wait is on the clock
	// before the check, so valid is never lowered and raised within the same step.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_times.size() != 0);
	endtask

	// Zero and all-ones fields, full fractions, and fractions on either side of the point
	// where the microsecond correction steps up.
	task automatic test_field_extremes();
		send_reply(pack_reply('0, '0, '0, '0, '0, '0, '0, '0));
		send_reply(pack_reply('1, '1, '1, '1, '1, '1, '1, 20'hfffff));
		send_reply(pack_reply(SAMPLE_NTP, '1, SAMPLE_NTP, '0, SAMPLE_NTP, '1,
			SAMPLE_UNIX, 20'd999999));
		send_reply(pack_reply(SAMPLE_NTP, 32'h0200_0000, SAMPLE_NTP, 32'h01ff_fc00,
			SAMPLE_NTP, 32'h0200_0000, SAMPLE_UNIX, 20'd500000));
		send_reply(pack_reply(SAMPLE_NTP, '0, SAMPLE_NTP, 32'h8000_0000,
			SAMPLE_NTP, 32'h8000_0000, SAMPLE_UNIX, '0));
	endtask

	// NTP seconds before 1970 wrap when rebased and count as times far in the future.
	task automatic test_pre_1970_seconds();
		send_reply(pack_reply(32'h10, '0, SAMPLE_NTP, '0, SAMPLE_NTP, '0, SAMPLE_UNIX, '0));
		send_reply(pack_reply(NTP_UNIX_GAP - 32'd1, '1, NTP_UNIX_GAP - 32'd1, '0,
			NTP_UNIX_GAP - 32'd1, 32'd1234, '1, 20'd999999));
		send_reply(pack_reply(SAMPLE_NTP, '0, 32'h1000, '0, 32'h1000, '0, SAMPLE_UNIX, '0));
	endtask

	// Corrected seconds wrapping past the top and below zero, both through the seconds
	// part of the offset and through a microsecond carry or borrow.
	task automatic test_seconds_wrap();
		send_reply(pack_reply(NTP_UNIX_GAP - 32'd16, '0, NTP_UNIX_GAP - 32'd1, '1,
			NTP_UNIX_GAP - 32'd1, '1, 32'hffff_fff0, 20'd999999));
		send_reply(pack_reply(NTP_UNIX_GAP + 32'd4, '0, NTP_UNIX_GAP, '0, NTP_UNIX_GAP, '0,
			32'd4, '0));
		send_reply(pack_reply(NTP_UNIX_GAP + 32'd1, 32'h8000_0000, NTP_UNIX_GAP, '0,
			NTP_UNIX_GAP, '0, '0, '0));
		send_reply(pack_reply(NTP_UNIX_GAP - 32'd1, '0, NTP_UNIX_GAP + 32'd4, '0,
			NTP_UNIX_GAP + 32'd4, '0, '1, '0));
		send_reply(pack_reply(NTP_UNIX_GAP + 32'd5, '0, NTP_UNIX_GAP - 32'd5, '0,
			NTP_UNIX_GAP - 32'd5, '0, '0, '0));
	endtask

	// Carry and borrow in the microseconds, halving of odd sums toward zero in both signs,
	// and local microseconds beyond the legal range.
	task automatic test_micros_normalization();
		send_reply(pack_reply(SAMPLE_NTP, '0, SAMPLE_NTP, 32'h8000_0000,
			SAMPLE_NTP, 32'h8000_0000, SAMPLE_UNIX, 20'd999999));
		send_reply(pack_reply(SAMPLE_NTP, 32'h8000_0000, SAMPLE_NTP, '0,
			SAMPLE_NTP, '0, SAMPLE_UNIX, 20'd1));
		send_reply(pack_reply(SAMPLE_NTP, '0, SAMPLE_NTP, '0, SAMPLE_NTP, '0,
			SAMPLE_UNIX, 20'd1));
		send_reply(pack_reply(SAMPLE_NTP, '0, SAMPLE_NTP, '0, SAMPLE_NTP, 32'd4295,
			SAMPLE_UNIX, '0));
		send_reply(pack_reply(SAMPLE_NTP, '0, SAMPLE_NTP, '0, SAMPLE_NTP, '0,
			SAMPLE_UNIX, 20'd1000000));
		send_reply(pack_reply(SAMPLE_NTP, 32'h8000_0000, SAMPLE_NTP, '0, SAMPLE_NTP, '0,
			SAMPLE_UNIX, 20'hfffff));
	endtask

	task automatic test_random_replies(input int count, input bit send_on, input bit recv_on);
		send_idle = send_on;
		recv_idle = recv_on;
		repeat (count) send_reply(random_reply());
	endtask

	// The sender stops until the pipeline is empty, then refills it from cold.
	task automatic test_drain_pause();
		send_idle = 1'b0;
		recv_idle = 1'b1;
		repeat (3) begin
			repeat (10) send_reply(random_reply());
			wait_drained();
		end
	endtask

	// Unrelated random values in every field, so every bit of every field toggles.
	task automatic test_random_noise(input int count);
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (count) begin
			send_reply(pack_reply($urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom(), 20'($urandom_range(0, 20'hfffff))));
		end
	endtask

	// Receiver side: before each result it may hold stall for a few cycles, then takes the
	// next word the block offers. Stalls also land while the pipeline is empty or filling.
	initial begin : result_sink
		int hold;
		forever begin
			hold = recv_idle ? $urandom_range(0, 5) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// Each accepted result is matched against the oldest expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_times.size() == 0) begin
				report_mismatch($sformatf("unexpected word: seconds %h micros %h",
					corrected_seconds, corrected_micros));
			end else begin
				oldest_time = pending_times.pop_front();
				if (corrected_seconds !== oldest_time.seconds)
					report_mismatch($sformatf("corrected_seconds %h, expected %h",
						corrected_seconds, oldest_time.seconds));
				if (corrected_micros !== oldest_time.micros)
					report_mismatch($sformatf("corrected_micros %h, expected %h",
						corrected_micros, oldest_time.micros));
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_pre_1970_seconds();
		test_seconds_wrap();
		test_micros_normalization();
		// Random replies under each mix of idling: both sides random, a stalling receiver against
		// a full-rate sender so in_stall backs up, full throughput, and only the sender idling.
		test_random_replies(400, 1'b1, 1'b1);
		test_random_replies(350, 1'b0, 1'b1);
		test_random_replies(300, 1'b0, 1'b0);
		test_random_replies(250, 1'b1, 1'b0);
		test_drain_pause();
		test_random_noise(300);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
